// ----- design/dhf_pkg.sv -----
// Shared constants and codes for the disparity hole fill block.
package dhf_pkg;

    // Frame store geometry; both sides are powers of two so an address is {row, col}.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = ROW_W + COL_W;

    // Frame size registers and ring radius.
    localparam int DIM_W      = 11;
    // Signed coordinate wide enough for center plus or minus radius.
    localparam int COORD_W    = DIM_W + 2;
    localparam int PIX_W      = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Reset value of both frame size registers.
    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

    // Transaction function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

// ----- design/disparity_hole_fill_nearest.sv -----
// Disparity hole fill: frame store plus a ring search sequencer.
//
// Input channel (in_valid/in_ready) carries func, row, col and pixel_value.
// A load transaction (func = 0) writes pixel_value into the frame store in
// the cycle it is accepted and produces no result. A query transaction
// (func = 1) produces exactly one result on the output channel
// (out_valid/out_ready): filled_value and found.
// A query whose pixel is nonzero is read, checked in the check state and passed
// through the done state to the output register; one outside the frame goes
// straight to the done state. A hole walks square rings of growing radius around
// the pixel through the single read port of the frame store, one pixel per cycle
// with a setup step before each ring side, and stops at the first nonzero pixel.
// An all-zero frame runs up to radius max(width, height) and returns found 0.
// The block takes one query at a time; in_ready is high only when idle.
// A result waits in the output register while the receiver stalls, and the
// next transaction is accepted meanwhile; a later result waits until the
// output register is free.
// Reset sets frame width and height to 1024 and empties the output register; the
// frame store is not cleared and must be loaded before use. Configuration (cfg_we,
// cfg_index, cfg_data) must be written only while idle; the block does not enforce it.
module disparity_hole_fill_nearest
    import dhf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [ROW_W-1:0]     row,
    input  logic [COL_W-1:0]     col,
    input  logic [PIX_W-1:0]     pixel_value,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     filled_value,
    output logic                 found
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEG_LEFT,
        SEG_RIGHT,
        SEG_TOP,
        SEG_BOTTOM
    } seg_t;

    // Registers and their next values.
    state_t                  state_reg, state_next;
    seg_t                    seg_reg, seg_next;
    logic [DIM_W-1:0]        frame_width_reg, frame_width_next;
    logic [DIM_W-1:0]        frame_height_reg, frame_height_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [DIM_W-1:0]        k_reg, k_next;
    logic [DIM_W-1:0]        kmax_reg, kmax_next;
    logic [COL_W-1:0]        pos_reg, pos_next;
    logic [COL_W-1:0]        end_reg, end_next;
    logic [COL_W-1:0]        fix_reg, fix_next;
    logic                    pend_reg, pend_next;
    logic [PIX_W-1:0]        res_value_reg, res_value_next;
    logic                    res_found_reg, res_found_next;
    logic                    out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]        out_value_reg, out_value_next;
    logic                    out_found_reg, out_found_next;

    // Frame store and its registered read data.
    logic [PIX_W-1:0]        frame_store [MAX_WIDTH*MAX_HEIGHT];
    logic [PIX_W-1:0]        rd_data_reg;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    mem_we;

    // Effective frame size and derived values.
    logic [DIM_W-1:0]        width_eff, height_eff;
    logic                    in_accept;
    logic                    pend_hit;

    // Ring side setup signals.
    logic signed [COORD_W-1:0] kk, rs, cs;
    logic signed [COORD_W-1:0] fix_s, lo_s, hi_s, fix_lim, run_lim;
    logic signed [COORD_W-1:0] lo_c, hi_c;
    logic                      seg_ok;
    logic                      vertical;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_accept    = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign filled_value = out_value_reg;
    assign found        = out_found_reg;

    // Clamp the frame size registers to the store size.
    assign width_eff  = (frame_width_reg > DIM_W'(MAX_WIDTH)) ?
                        DIM_W'(MAX_WIDTH) : frame_width_reg;
    assign height_eff = (frame_height_reg > DIM_W'(MAX_HEIGHT)) ?
                        DIM_W'(MAX_HEIGHT) : frame_height_reg;

    assign mem_we   = in_accept && (func == FUNC_LOAD);
    assign pend_hit = pend_reg && (rd_data_reg != '0);
    assign vertical = (seg_reg == SEG_LEFT) || (seg_reg == SEG_RIGHT);

    // Read address: the queried pixel while idle, the walk position otherwise.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_addr = {row, col};
        end
        else if (vertical)
        begin
            rd_addr = {pos_reg[ROW_W-1:0], fix_reg};
        end
        else
        begin
            rd_addr = {fix_reg[ROW_W-1:0], pos_reg};
        end
    end

    // Frame store: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_store[{row, col}] <= pixel_value;
        end
        rd_data_reg <= frame_store[rd_addr];
    end

    // Bounds of the current ring side, clipped to the frame.
    always_comb
    begin
        kk = $signed({2'b00, k_reg});
        rs = $signed({{(COORD_W-ROW_W){1'b0}}, row_reg});
        cs = $signed({{(COORD_W-COL_W){1'b0}}, col_reg});
        unique case (seg_reg)
            SEG_LEFT:
            begin
                fix_s   = cs - kk;
                lo_s    = rs - kk;
                hi_s    = rs + kk;
                fix_lim = $signed({2'b00, width_eff});
                run_lim = $signed({2'b00, height_eff});
            end
            SEG_RIGHT:
            begin
                fix_s   = cs + kk;
                lo_s    = rs - kk;
                hi_s    = rs + kk;
                fix_lim = $signed({2'b00, width_eff});
                run_lim = $signed({2'b00, height_eff});
            end
            SEG_TOP:
            begin
                fix_s   = rs - kk;
                lo_s    = cs - kk + COORD_W'(1);
                hi_s    = cs + kk - COORD_W'(1);
                fix_lim = $signed({2'b00, height_eff});
                run_lim = $signed({2'b00, width_eff});
            end
            default:
            begin
                fix_s   = rs + kk;
                lo_s    = cs - kk + COORD_W'(1);
                hi_s    = cs + kk;
                fix_lim = $signed({2'b00, height_eff});
                run_lim = $signed({2'b00, width_eff});
            end
        endcase
        lo_c   = (lo_s < 0) ? '0 : lo_s;
        hi_c   = (hi_s > run_lim - COORD_W'(1)) ? run_lim - COORD_W'(1) : hi_s;
        seg_ok = (fix_s >= 0) && (fix_s < fix_lim) && (lo_c <= hi_c);
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        seg_next          = seg_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        k_next            = k_reg;
        kmax_next         = kmax_reg;
        pos_next          = pos_reg;
        end_next          = end_reg;
        fix_next          = fix_reg;
        pend_next         = 1'b0;
        res_value_next    = res_value_reg;
        res_found_next    = res_found_reg;
        out_valid_next    = out_valid_reg;
        out_value_next    = out_value_reg;
        out_found_next    = out_found_reg;

        // Configuration writes; unknown indexes are ignored.
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default:          ;
            endcase
        end

        // Output register empties when the receiver takes the transaction.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (func == FUNC_QUERY))
                begin
                    row_next  = row;
                    col_next  = col;
                    kmax_next = (width_eff > height_eff) ? width_eff : height_eff;
                    if ((DIM_W'(row) < height_eff) && (DIM_W'(col) < width_eff))
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        res_value_next = '0;
                        res_found_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_CHECK:
            begin
                if (rd_data_reg != '0)
                begin
                    res_value_next = rd_data_reg;
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    k_next     = DIM_W'(1);
                    seg_next   = SEG_LEFT;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (pend_hit)
                begin
                    // Last read of the previous side hit.
                    res_value_next = rd_data_reg;
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (k_reg > kmax_reg)
                begin
                    // Every ring searched without a nonzero pixel.
                    res_value_next = '0;
                    res_found_next = 1'b0;
                    state_next     = ST_DONE;
                end
                else if (seg_ok)
                begin
                    pos_next   = lo_c[COL_W-1:0];
                    end_next   = hi_c[COL_W-1:0];
                    fix_next   = fix_s[COL_W-1:0];
                    state_next = ST_SCAN;
                end
                else if (seg_reg == SEG_BOTTOM)
                begin
                    seg_next = SEG_LEFT;
                    k_next   = k_reg + DIM_W'(1);
                end
                else
                begin
                    seg_next = seg_t'(seg_reg + 2'd1);
                end
            end
            ST_SCAN:
            begin
                if (pend_hit)
                begin
                    res_value_next = rd_data_reg;
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    // The read at pos_reg was issued this cycle.
                    pend_next = 1'b1;
                    pos_next  = pos_reg + COL_W'(1);
                    if (pos_reg == end_reg)
                    begin
                        state_next = ST_SETUP;
                        if (seg_reg == SEG_BOTTOM)
                        begin
                            seg_next = SEG_LEFT;
                            k_next   = k_reg + DIM_W'(1);
                        end
                        else
                        begin
                            seg_next = seg_t'(seg_reg + 2'd1);
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_found_next = res_found_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            seg_reg          <= SEG_LEFT;
            frame_width_reg  <= DIM_RESET;
            frame_height_reg <= DIM_RESET;
            row_reg          <= '0;
            col_reg          <= '0;
            k_reg            <= '0;
            kmax_reg         <= '0;
            pos_reg          <= '0;
            end_reg          <= '0;
            fix_reg          <= '0;
            pend_reg         <= 1'b0;
            res_value_reg    <= '0;
            res_found_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_value_reg    <= '0;
            out_found_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            seg_reg          <= seg_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            k_reg            <= k_next;
            kmax_reg         <= kmax_next;
            pos_reg          <= pos_next;
            end_reg          <= end_next;
            fix_reg          <= fix_next;
            pend_reg         <= pend_next;
            res_value_reg    <= res_value_next;
            res_found_reg    <= res_found_next;
            out_valid_reg    <= out_valid_next;
            out_value_reg    <= out_value_next;
            out_found_reg    <= out_found_next;
        end
    end

    // A result with found set carries a nonzero value, and found clear means zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> filled_value != '0)
        else $error("found result with zero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> filled_value == '0)
        else $error("not-found result with nonzero value");

    // A pending read only exists while walking ring sides.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN) || (state_reg == ST_SETUP))
        else $error("pending read outside the ring walk");

    // The walk never scans beyond the largest ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> k_reg <= kmax_reg)
        else $error("ring radius beyond limit");

endmodule

// ----- tb/sv/tb_disparity_hole_fill_nearest.sv -----
// Self-checking testbench for the disparity hole fill block with a ring search predictor.
module tb_disparity_hole_fill_nearest;
    import dhf_pkg::*;

    // Run limits and handshake timing.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;

    // Register indexes that decode to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] filled_value;
        logic             found;
    } fill_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 func;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic [PIX_W-1:0]     pixel_value;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIX_W-1:0]     filled_value;
    logic                 found;

    // Shadow of the frame store (only written entries exist) and of the frame size.
    logic [PIX_W-1:0] disparity_map [int];
    logic [DIM_W-1:0] cur_width;
    logic [DIM_W-1:0] cur_height;

    // Results still owed by the block, oldest first.
    fill_result_t expected_fills [$];
    fill_result_t want;

    int fail_count;
    int cycle_count;
    bit idle_on;
    bit hold_request;
    bit result_taken;

    disparity_hole_fill_nearest uut (.*);

    // Clock with a period of 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Draws an idle count, zero about a third of the time.
    function automatic int draw_wait();
        if ($urandom_range(2, 0) == 0)
            return 0;
        return $urandom_range(19, 0);
    endfunction

    // Draws a disparity byte that is a hole with the given percentage.
    function automatic logic [PIX_W-1:0] rand_pixel(input int zero_pct);
        if ($urandom_range(99, 0) < zero_pct)
            return '0;
        return PIX_W'($urandom_range(255, 1));
    endfunction

    // Reads the shadow store; an entry never written clears all_written.
    function automatic logic [PIX_W-1:0] stored_pixel(input int r, input int c,
                                                      inout bit all_written);
        int key;
        key = r * MAX_WIDTH + c;
        if (disparity_map.exists(key))
            return disparity_map[key];
        all_written = 1'b0;
        return '0;
    endfunction

    // Scans one ring side, clipped to the frame, and stops at the first nonzero byte.
    function automatic bit scan_side(input bit vertical, input int fixed, input int lo,
                                     input int hi, input int w, input int h,
                                     output logic [PIX_W-1:0] v, inout bit all_written);
        int fixed_lim;
        int span_lim;
        v = '0;
        fixed_lim = vertical ? w : h;
        span_lim  = vertical ? h : w;
        if (fixed < 0 || fixed >= fixed_lim)
            return 1'b0;
        if (lo < 0)
            lo = 0;
        if (hi > span_lim - 1)
            hi = span_lim - 1;
        for (int i = lo; i <= hi && all_written; i++)
        begin
            v = vertical ? stored_pixel(i, fixed, all_written)
                         : stored_pixel(fixed, i, all_written);
            if (v != 0)
                return 1'b1;
        end
        v = '0;
        return 1'b0;
    endfunction

    // Predicts the filled value of a query at (r, c) from the shadow state.
    function automatic void predict_fill(input int r, input int c, output fill_result_t res,
                                         output bit all_written);
        int w;
        int h;
        int kmax;
        logic [PIX_W-1:0] v;
        bit hit;
        all_written = 1'b1;
        hit = 1'b0;
        v = '0;
        w = (cur_width > MAX_WIDTH) ? MAX_WIDTH : int'(cur_width);
        h = (cur_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_height);
        if (r < h && c < w)
        begin
            v = stored_pixel(r, c, all_written);
            hit = (v != 0);
            kmax = (w > h) ? w : h;
            // Rings: left column, right column, top row, bottom row.
            for (int k = 1; k <= kmax && !hit && all_written; k++)
            begin
                hit = scan_side(1'b1, c - k, r - k, r + k, w, h, v, all_written);
                if (!hit)
                    hit = scan_side(1'b1, c + k, r - k, r + k, w, h, v, all_written);
                if (!hit)
                    hit = scan_side(1'b0, r - k, c - k + 1, c + k - 1, w, h, v, all_written);
                if (!hit)
                    hit = scan_side(1'b0, r + k, c - k + 1, c + k, w, h, v, all_written);
            end
            if (!hit)
                v = '0;
        end
        res.filled_value = v;
        res.found = hit;
    endfunction

    // Offers one transaction, after a random gap if idle_on, and holds it until accepted.
    task automatic send_item(input logic f, input int r, input int c,
                             input logic [PIX_W-1:0] pv);
        int gap;
        gap = idle_on ? draw_wait() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        row         <= ROW_W'(r);
        col         <= COL_W'(c);
        pixel_value <= pv;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic load_pixel(input int r, input int c, input logic [PIX_W-1:0] v);
        send_item(FUNC_LOAD, r, c, v);
        disparity_map[r * MAX_WIDTH + c] = v;
    endtask

    // A query is only sent when every byte its search reads has been loaded.
    task automatic query_pixel(input int r, input int c);
        fill_result_t res;
        bit all_written;
        predict_fill(r, c, res, all_written);
        if (!all_written)
            return;
        send_item(FUNC_QUERY, r, c, PIX_W'($urandom_range(255, 0)));
        expected_fills.push_back(res);
    endtask

    // Waits until every result has arrived and the block has gone quiet.
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_fills.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cur_width = value;
            REG_FRAME_HEIGHT: cur_height = value;
            default: ;
        endcase
    endtask

    // Opposite corners of the full frame, a nonzero pixel and a hole.
    task automatic test_full_frame_corners();
        load_pixel(0, 0, 8'hFF);
        query_pixel(0, 0);
        load_pixel(1023, 1023, 8'h00);
        load_pixel(1022, 1022, 8'h80);
        query_pixel(1023, 1023);
    endtask

    // A 3x3 frame: each new hit lies earlier in the ring order than the last.
    task automatic test_ring_order();
        wait_drain();
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                load_pixel(r, c, (r == 2 && c == 1) ? 8'd7 : 8'd0);
        query_pixel(1, 1);
        load_pixel(0, 1, 8'd9);
        query_pixel(1, 1);
        load_pixel(1, 2, 8'd11);
        query_pixel(1, 1);
        load_pixel(2, 0, 8'd13);
        query_pixel(1, 1);
    endtask

    // All-zero frame, a query outside the frame, zero width, and unused indexes.
    task automatic test_empty_and_outside();
        wait_drain();
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        query_pixel(0, 0);
        query_pixel(5, 5);
        wait_drain();
        write_reg(REG_FRAME_WIDTH, 11'd0);
        query_pixel(0, 0);
        wait_drain();
        write_reg(REG_UNUSED_A, 11'd5);
        write_reg(REG_UNUSED_B, 11'd2047);
        query_pixel(0, 0);
    endtask

    // Size registers above the store size are clamped to it.
    task automatic test_oversized_dims();
        wait_drain();
        write_reg(REG_FRAME_WIDTH, 11'd2047);
        write_reg(REG_FRAME_HEIGHT, 11'd2047);
        query_pixel(1023, 1023);
        query_pixel(0, 0);
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        wait_drain();
        idle_on = 1'b0;
        write_reg(REG_FRAME_WIDTH, 11'd4);
        write_reg(REG_FRAME_HEIGHT, 11'd4);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                load_pixel(r, c, rand_pixel(0));
        hold_request = 1'b1;
        for (int n = 0; n < 12; n++)
            query_pixel($urandom_range(3, 0), $urandom_range(3, 0));
        wait_drain();
        idle_on = 1'b1;
    endtask

    // Random small frames, fully loaded, then a random mix of loads and queries.
    task automatic test_random_frames(input int phases);
        int w;
        int h;
        int zero_pct;
        for (int p = 0; p < phases; p++)
        begin
            case (p % 4)
                0:
                begin
                    w = $urandom_range(12, 2);
                    h = $urandom_range(12, 2);
                    zero_pct = 30;
                end
                1:
                begin
                    w = 1;
                    h = $urandom_range(12, 1);
                    zero_pct = 50;
                end
                2:
                begin
                    w = $urandom_range(12, 1);
                    h = 1;
                    zero_pct = 50;
                end
                default:
                begin
                    w = $urandom_range(5, 1);
                    h = $urandom_range(5, 1);
                    zero_pct = 90;
                end
            endcase
            wait_drain();
            idle_on = (p != 2);
            write_reg(REG_FRAME_WIDTH, DIM_W'(w));
            write_reg(REG_FRAME_HEIGHT, DIM_W'(h));
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++)
                    load_pixel(r, c, rand_pixel(zero_pct));
            for (int n = 0; n < 80; n++)
            begin
                if ($urandom_range(99, 0) < 30)
                begin
                    if ($urandom_range(99, 0) < 70)
                        load_pixel($urandom_range(h - 1, 0), $urandom_range(w - 1, 0),
                                   rand_pixel(zero_pct));
                    else
                        load_pixel($urandom_range(1023, 0), $urandom_range(1023, 0),
                                   rand_pixel(zero_pct));
                end
                else if ($urandom_range(99, 0) < 85)
                    query_pixel($urandom_range(h - 1, 0), $urandom_range(w - 1, 0));
                else
                    query_pixel($urandom_range(1023, 0), $urandom_range(1023, 0));
            end
        end
        idle_on = 1'b1;
    endtask

    // Receiver: random stalls after each result if idle_on, plus one long hold on request.
    initial
    begin : receiver
        int res_wait;
        int hold_left;
        res_wait = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (result_taken)
            begin
                result_taken = 1'b0;
                res_wait = idle_on ? draw_wait() : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (res_wait > 0)
            begin
                res_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            result_taken = 1'b1;
            if (expected_fills.size() == 0)
            begin
                $error("unexpected result: filled_value %0d found %0d", filled_value, found);
                fail_count++;
            end
            else
            begin
                want = expected_fills.pop_front();
                if (filled_value !== want.filled_value)
                begin
                    $error("filled_value: expected %0d, got %0d", want.filled_value,
                           filled_value);
                    fail_count++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    fail_count++;
                end
            end
        end
    end

    // Reset, then the tests in turn, then the verdict.
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_FRAME_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        func         = FUNC_LOAD;
        row          = '0;
        col          = '0;
        pixel_value  = '0;
        cur_width    = DIM_RESET;
        cur_height   = DIM_RESET;
        fail_count   = 0;
        cycle_count  = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        result_taken = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_full_frame_corners();
        test_ring_order();
        test_empty_and_outside();
        test_oversized_dims();
        test_backpressure();
        test_random_frames(10);

        wait_drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
